### design/dmy_pkg.sv
package dmy_pkg;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam int unsigned DAY_W  = 7;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned CNT_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX      = 3'd7;
    localparam logic [CNT_W-1:0] DM_DIGITS    = 3'd2;
    localparam logic [CNT_W-1:0] YEAR_DIGITS  = 3'd4;
    localparam logic [DAY_W-1:0] MONTH_LAST   = 7'd12;
    localparam logic [DAY_W-1:0] MONTH_FEB    = 7'd2;
    localparam logic [4:0]       FEB_LEAP_LEN = 5'd29;

    typedef enum logic [3:0] {
        PH_DAY   = 4'b0001,
        PH_MONTH = 4'b0010,
        PH_YEAR  = 4'b0100,
        PH_ERR   = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_BAD_DATE = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [DAY_W-1:0]    day;
        logic [DAY_W-1:0]    month;
        logic [YEAR_W-1:0]   year;
    } t_result;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Divisible by 4 from the decimal digits; centuries fall back to the upper pair
    function automatic logic is_leap(input logic [3:0] d3, input logic [3:0] d2,
                                     input logic [3:0] d1, input logic [3:0] d0);
        logic [1:0] rem;
        if (d1 == 4'd0 && d0 == 4'd0) begin
            rem = {d3[0], 1'b0} + d2[1:0];
        end else begin
            rem = {d1[0], 1'b0} + d0[1:0];
        end
        return rem == 2'd0;
    endfunction

endpackage

### design/day_month_year_text_parser_core.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+----------------------------------
// input    | i_in_valid   | o_in_stall   | i_ch, i_last
// output   | o_out_valid  | i_out_stall  | o_status, o_day, o_month, o_year
//
// One character per cycle unless a last character is held back; each result is registered.
// The rate is set by the single parse step between the input and result registers.
// Reset is synchronous, active low, and returns the parser to reading the day.
// A stalled result only blocks a last character; other characters keep flowing.
module day_month_year_text_parser_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_ch,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [dmy_pkg::DAY_W-1:0]    o_day,
    output logic [dmy_pkg::DAY_W-1:0]    o_month,
    output logic [dmy_pkg::YEAR_W-1:0]   o_year
);
    import dmy_pkg::*;

    logic       in_vld;
    logic [7:0] in_ch;
    logic       in_last;
    logic       take;
    logic       res_vld;
    logic       out_hold;
    t_result    res;
    t_result    out_res;

    dmy_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .i_take  (take),
        .o_stall (o_in_stall),
        .o_valid (in_vld),
        .o_ch    (in_ch),
        .o_last  (in_last)
    );

    dmy_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_vld),
        .i_ch        (in_ch),
        .i_last      (in_last),
        .i_out_hold  (out_hold),
        .o_take      (take),
        .o_res_valid (res_vld),
        .o_res       (res)
    );

    dmy_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_vld),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_hold  (out_hold),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_status = out_res.status;
    assign o_day    = out_res.day;
    assign o_month  = out_res.month;
    assign o_year   = out_res.year;

endmodule

### design/dmy_in_reg.sv
module dmy_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_ch,
    output logic       o_last
);
    logic       r_vld;
    logic [7:0] r_ch;
    logic       r_last;

    assign o_stall = r_vld && !i_take;
    assign o_valid = r_vld;
    assign o_ch    = r_ch;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

endmodule

### design/dmy_parse.sv
module dmy_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    input  logic             i_out_hold,
    output logic             o_take,
    output logic             o_res_valid,
    output dmy_pkg::t_result o_res
);
    import dmy_pkg::*;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [DAY_W-1:0]    r_mon, n_mon;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [3:0][3:0]     r_ydig, n_ydig;
    t_status             r_err, n_err;

    logic                dig;
    logic [3:0]          d;
    logic [DAY_W-1:0]    dm_next;
    logic [YEAR_W+2:0]   year_sum;
    logic [CNT_W-1:0]    cnt_inc;
    logic [4:0]          lim;
    t_status             status;

    assign o_take      = i_valid && !(i_last && i_out_hold);
    assign o_res_valid = o_take && i_last;

    assign dig      = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign d        = i_ch[3:0];
    assign cnt_inc  = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 3'd1;
    assign year_sum = {r_year, 3'b000} + {2'b00, r_year, 1'b0} + {{(YEAR_W-1){1'b0}}, d};

    always_comb begin
        logic [DAY_W-1:0] cur;
        cur     = r_phase == PH_MONTH ? r_mon : r_day;
        dm_next = 7'(({4'b0000, cur} << 3) + ({4'b0000, cur} << 1) + {7'b0000000, d});
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_day   = r_day;
        n_mon   = r_mon;
        n_year  = r_year;
        n_ydig  = r_ydig;
        n_err   = r_err;
        case (r_phase)
            PH_DAY, PH_MONTH: begin
                if (i_ch == CH_DOT) begin
                    if (r_cnt == '0 || r_cnt > DM_DIGITS) begin
                        n_phase = PH_ERR;
                        n_err   = ST_BAD_LEN;
                    end else begin
                        n_phase = r_phase == PH_DAY ? PH_MONTH : PH_YEAR;
                        n_cnt   = '0;
                    end
                end else if (dig) begin
                    if (r_cnt < DM_DIGITS) begin
                        if (r_phase == PH_DAY) begin
                            n_day = dm_next;
                        end else begin
                            n_mon = dm_next;
                        end
                    end
                    n_cnt = cnt_inc;
                end else begin
                    n_phase = PH_ERR;
                    n_err   = ST_BAD_CHAR;
                end
            end
            PH_YEAR: begin
                if (dig) begin
                    if (r_cnt < YEAR_DIGITS) begin
                        n_year = year_sum[YEAR_W-1:0];
                        n_ydig = {r_ydig[2:0], d};
                    end
                    n_cnt = cnt_inc;
                end else begin
                    n_phase = PH_ERR;
                    n_err   = ST_BAD_CHAR;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        lim = month_len(n_mon[3:0]);
        if (n_mon == MONTH_FEB && is_leap(n_ydig[3], n_ydig[2], n_ydig[1], n_ydig[0])) begin
            lim = FEB_LEAP_LEN;
        end
        if (n_phase == PH_ERR) begin
            status = n_err;
        end else if (n_phase != PH_YEAR) begin
            status = ST_BAD_LEN;
        end else if (n_cnt == '0 || n_cnt > YEAR_DIGITS) begin
            status = ST_BAD_LEN;
        end else if (n_mon == '0 || n_mon > MONTH_LAST || n_day == '0) begin
            status = ST_BAD_DATE;
        end else if (n_day > {2'b00, lim}) begin
            status = ST_BAD_DATE;
        end else begin
            status = ST_OK;
        end
        o_res.status = status;
        o_res.day    = status == ST_OK ? n_day  : '0;
        o_res.month  = status == ST_OK ? n_mon  : '0;
        o_res.year   = status == ST_OK ? n_year : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_last)) begin
            r_phase <= PH_DAY;
            r_cnt   <= '0;
            r_day   <= '0;
            r_mon   <= '0;
            r_year  <= '0;
            r_ydig  <= '0;
            r_err   <= ST_OK;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_day   <= n_day;
            r_mon   <= n_mon;
            r_year  <= n_year;
            r_ydig  <= n_ydig;
            r_err   <= n_err;
        end
    end

endmodule

### design/dmy_out_reg.sv
module dmy_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dmy_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_hold,
    output logic             o_valid,
    output dmy_pkg::t_result o_res
);
    import dmy_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_hold  = r_vld && i_stall;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### design/dmy_checker.sv
module dmy_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [7:0]                   i_ch,
    input logic                         i_last,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [1:0]                   o_status,
    input logic [dmy_pkg::DAY_W-1:0]    o_day,
    input logic [dmy_pkg::DAY_W-1:0]    o_month,
    input logic [dmy_pkg::YEAR_W-1:0]   o_year
);
    import dmy_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_status) && $stable(o_day) && $stable(o_month) && $stable(o_year))
        else $error("stalled result word changed");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |->
            o_day != '0 && o_day <= 7'd31 && o_month != '0 && o_month <= MONTH_LAST
            && o_year <= 14'd9999)
        else $error("accepted date out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_day == '0 && o_month == '0 && o_year == '0)
        else $error("fields not cleared on error status");

endmodule

bind day_month_year_text_parser_core dmy_checker u_dmy_checker (.*);
